// ===== sv/pbrf_pkg.sv =====
// Shared types, codes and helpers for the PE base relocation fixup block.
`default_nettype none
package pbrf_pkg;

   localparam logic [3:0] TYPE_ABSOLUTE = 4'd0;
   localparam logic [3:0] TYPE_HIGH     = 4'd1;
   localparam logic [3:0] TYPE_LOW      = 4'd2;
   localparam logic [3:0] TYPE_HIGHLOW  = 4'd3;
   localparam logic [3:0] TYPE_HI20     = 4'd5;
   localparam logic [3:0] TYPE_LOW12I   = 4'd7;   // also ARM MOV32T
   localparam logic [3:0] TYPE_LOW12S   = 4'd8;
   localparam logic [3:0] TYPE_DIR64    = 4'd10;

   localparam logic [1:0] ARCH_RISCV = 2'd1;
   localparam logic [1:0] ARCH_THUMB = 2'd2;

   localparam logic [1:0] SZ_NONE = 2'd0;
   localparam logic [1:0] SZ_16   = 2'd1;
   localparam logic [1:0] SZ_32   = 2'd2;
   localparam logic [1:0] SZ_64   = 2'd3;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_BADTYPE = 2'd1;
   localparam logic [1:0] STS_NOHI20  = 2'd2;
   localparam logic [1:0] STS_HALTED  = 2'd3;

   localparam logic CSR_LOAD_OFFSET = 1'b0;
   localparam logic CSR_ARCH_MODE   = 1'b1;

   localparam logic [31:0] RV_ROUND = 32'h0000_0800;

   typedef struct packed {
      logic [15:0] entry;
      logic [31:0] page_base;
      logic [63:0] target_data;
   } item_type;

   typedef struct packed {
      logic [31:0] write_addr;
      logic [63:0] write_data;
      logic [1:0]  write_size;
      logic [1:0]  status;
      logic        last;
   } res_type;

   typedef struct packed {
      logic        hi_pending;
      logic [31:0] hi_addr;
      logic [31:0] hi_word;
      logic        halted;
   } st_type;

   typedef struct packed {
      logic [63:0] load_offset;
      logic [1:0]  arch_mode;
   } cfg_type;

   // Thumb MOVW/MOVT immediate imm4:i:imm3:imm8 from one 32-bit instruction.
   function automatic logic [15:0] thumb_imm(input logic [31:0] word);
      return {word[3:0], word[10], word[30:28], word[23:16]};
   endfunction

   function automatic logic [31:0] thumb_put(input logic [31:0] word,
                                             input logic [15:0] imm);
      return {word[31], imm[10:8], word[27:24], imm[7:0],
              word[15:11], imm[11], word[9:4], imm[15:12]};
   endfunction

endpackage
`default_nettype wire

// ===== sv/pbrf_calc.sv =====
// Per-entry fixup logic: decodes one entry and forms its results and next state.
`default_nettype none
module pbrf_calc (
   input  pbrf_pkg::item_type item,
   input  pbrf_pkg::cfg_type  cfg,
   input  pbrf_pkg::st_type   st,
   output pbrf_pkg::res_type  res0,
   output pbrf_pkg::res_type  res1,
   output logic               two,
   output pbrf_pkg::st_type   st_in
);
   import pbrf_pkg::*;

   logic [3:0]  etype;
   logic [31:0] addr;
   logic [31:0] word;
   logic [31:0] off32;
   logic [15:0] sum16_hi;
   logic [15:0] sum16_lo;
   logic [31:0] sum32;
   logic [63:0] sum64;
   logic [31:0] th_val;
   logic [11:0] lo12;
   logic [31:0] rv_val;
   logic [31:0] rv_rnd;
   logic [31:0] hw;
   logic [31:0] lw;

   assign etype    = item.entry[15:12];
   assign addr     = item.page_base + {20'd0, item.entry[11:0]};
   assign word     = item.target_data[31:0];
   assign off32    = cfg.load_offset[31:0];
   assign sum16_hi = item.target_data[15:0] + cfg.load_offset[31:16];
   assign sum16_lo = item.target_data[15:0] + cfg.load_offset[15:0];
   assign sum32    = word + off32;
   assign sum64    = item.target_data + cfg.load_offset;
   assign th_val   = {thumb_imm(item.target_data[63:32]), thumb_imm(word)} + off32;
   assign lo12     = (etype == TYPE_LOW12I) ? word[31:20] : {word[31:25], word[11:7]};
   assign rv_val   = {st.hi_word[31:12], 12'd0} + {{20{lo12[11]}}, lo12} + off32;
   assign rv_rnd   = rv_val + RV_ROUND;
   assign hw       = {rv_rnd[31:12], st.hi_word[11:0]};
   assign lw       = (etype == TYPE_LOW12I) ? {rv_val[11:0], word[19:0]}
                   : {rv_val[11:5], word[24:12], rv_val[4:0], word[6:0]};

   always_comb begin
      res0  = '{write_addr: 32'd0, write_data: 64'd0, write_size: SZ_NONE,
                status: STS_OK, last: 1'b1};
      res1  = res0;
      two   = 1'b0;
      st_in = st;
      if (st.halted) begin
         res0.status = STS_HALTED;
      end else begin
         case (etype)
            TYPE_ABSOLUTE: begin
            end
            TYPE_HIGH: begin
               res0.write_addr = addr;
               res0.write_data = {48'd0, sum16_hi};
               res0.write_size = SZ_16;
            end
            TYPE_LOW: begin
               res0.write_addr = addr;
               res0.write_data = {48'd0, sum16_lo};
               res0.write_size = SZ_16;
            end
            TYPE_HIGHLOW: begin
               res0.write_addr = addr;
               res0.write_data = {32'd0, sum32};
               res0.write_size = SZ_32;
            end
            TYPE_DIR64: begin
               res0.write_addr = addr;
               res0.write_data = sum64;
               res0.write_size = SZ_64;
            end
            TYPE_HI20: begin
               if (cfg.arch_mode == ARCH_RISCV) begin
                  st_in.hi_pending = 1'b1;
                  st_in.hi_addr    = addr;
                  st_in.hi_word    = word;
               end else begin
                  res0.status  = STS_BADTYPE;
                  st_in.halted = 1'b1;
               end
            end
            TYPE_LOW12I, TYPE_LOW12S: begin
               if (etype == TYPE_LOW12I && cfg.arch_mode == ARCH_THUMB) begin
                  res0.write_addr = addr;
                  res0.write_data = {thumb_put(item.target_data[63:32], th_val[31:16]),
                                     thumb_put(word, th_val[15:0])};
                  res0.write_size = SZ_64;
               end else if (cfg.arch_mode != ARCH_RISCV) begin
                  res0.status  = STS_BADTYPE;
                  st_in.halted = 1'b1;
               end else if (!st.hi_pending) begin
                  res0.status  = STS_NOHI20;
                  st_in.halted = 1'b1;
               end else begin
                  res0.write_addr  = st.hi_addr;
                  res0.write_data  = {32'd0, hw};
                  res0.write_size  = SZ_32;
                  res0.last        = 1'b0;
                  res1.write_addr  = addr;
                  res1.write_data  = {32'd0, lw};
                  res1.write_size  = SZ_32;
                  two              = 1'b1;
                  st_in.hi_pending = 1'b0;
               end
            end
            default: begin
               res0.status  = STS_BADTYPE;
               st_in.halted = 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== sv/pbrf_outq.sv =====
// Result register with one spare slot for the second result of a paired entry.
`default_nettype none
module pbrf_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pbrf_pkg::res_type res0,
   input  pbrf_pkg::res_type res1,
   input  logic              two,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pbrf_pkg::res_type rsp
);
   import pbrf_pkg::*;

   logic    valid0_ff, valid0_in;
   logic    pend1_ff, pend1_in;
   res_type slot0_ff, slot0_in;
   res_type slot1_ff, slot1_in;

   assign free      = !valid0_ff || (rsp_ready && !pend1_ff);
   assign rsp_valid = valid0_ff;
   assign rsp       = slot0_ff;

   always_comb begin
      valid0_in = valid0_ff;
      pend1_in  = pend1_ff;
      slot0_in  = slot0_ff;
      slot1_in  = slot1_ff;
      if (push) begin
         valid0_in = 1'b1;
         pend1_in  = two;
         slot0_in  = res0;
         slot1_in  = res1;
      end else if (valid0_ff && rsp_ready) begin
         if (pend1_ff) begin
            slot0_in = slot1_ff;
            pend1_in = 1'b0;
         end else begin
            valid0_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         pend1_ff  <= 1'b0;
      end else begin
         valid0_ff <= valid0_in;
         pend1_ff  <= pend1_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_pend_needs_head: assert property (@(posedge clock) disable iff (reset)
      pend1_ff |-> valid0_ff && !slot0_ff.last)
      else $error("spare slot held behind an empty or final head");

   a_nonlast_has_pend: assert property (@(posedge clock) disable iff (reset)
      valid0_ff && !slot0_ff.last |-> pend1_ff)
      else $error("non-final result without its follower");

   a_pend_drains: assert property (@(posedge clock) disable iff (reset)
      valid0_ff && rsp_ready && pend1_ff |=> valid0_ff && slot0_ff.last)
      else $error("second result lost after first transfer");

   a_no_push_over_pend: assert property (@(posedge clock) disable iff (reset)
      push |-> !pend1_ff)
      else $error("new entry issued over a pending second result");

endmodule
`default_nettype wire

// ===== sv/pe_base_relocation_fixup.sv =====
// Top level of the PE base relocation fixup block: input stage, config, state, results.
//
//  channel | ports        | payload
//  --------+--------------+--------------------------------------------------
//  request | req_*        | entry, page_base, target_data
//  result  | rsp_*        | write_addr, write_data, write_size, status, last
//  config  | csr_*        | index 0 load_offset, index 1 arch_mode
//
// One entry per cycle while ready is high; an entry enters the input register, then
// is decoded and added in one pass into the result register, from which its result
// transfers. A RISC-V LOW12 pair gives two results and holds the next entry for one
// extra transfer. Reset clears the pending HI20, the halt flag and the config
// registers. Ready falls only while the input register holds an entry that cannot
// move: the result register is full and not draining, or a pair's second result
// is still queued.
`default_nettype none
module pe_base_relocation_fixup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_entry,
   input  logic [31:0] req_page_base,
   input  logic [63:0] req_target_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_write_addr,
   output logic [63:0] rsp_write_data,
   output logic [1:0]  rsp_write_size,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import pbrf_pkg::*;

   logic     in_valid_ff, in_valid_in;
   item_type item_ff, item_in;
   cfg_type  cfg_ff, cfg_in;
   st_type   st_ff, st_in;
   st_type   st_next;
   res_type  res0;
   res_type  res1;
   res_type  rsp;
   logic     two;
   logic     free;
   logic     issue;

   assign issue     = in_valid_ff && free;
   assign req_ready = !in_valid_ff || free;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         item_in     = '{entry: req_entry, page_base: req_page_base,
                         target_data: req_target_data};
      end else if (issue) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LOAD_OFFSET: cfg_in.load_offset = csr_wdata;
            CSR_ARCH_MODE:   cfg_in.arch_mode   = csr_wdata[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign st_in = issue ? st_next : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cfg_ff      <= '0;
         st_ff       <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
         st_ff       <= st_in;
      end
      item_ff <= item_in;
   end

   pbrf_calc u_calc (
      .item  (item_ff),
      .cfg   (cfg_ff),
      .st    (st_ff),
      .res0  (res0),
      .res1  (res1),
      .two   (two),
      .st_in (st_next)
   );

   pbrf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (issue),
      .res0      (res0),
      .res1      (res1),
      .two       (two),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_write_addr = rsp.write_addr;
   assign rsp_write_data = rsp.write_data;
   assign rsp_write_size = rsp.write_size;
   assign rsp_status     = rsp.status;
   assign rsp_last       = rsp.last;

endmodule
`default_nettype wire
